// ----- rtl/huff_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huff_pkg
// Shared types and defaults for the Huffman code builder.
// ----------------------------------------------------------------------------
package huff_pkg;

    localparam int DEF_MAX_SYMBOLS = 32;
    localparam int DEF_WEIGHT_BITS = 16;

    typedef struct packed {
        logic [7:0]  symbol;
        logic [15:0] weight;
        logic        last_symbol;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_symbol;
        logic [30:0] code_bits;
        logic [4:0]  code_length;
        logic        last_code;
        logic        too_many;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan_init;
        logic scan_issue;
        logic merge_a;
        logic merge_b;
        logic emit_init;
        logic walk_rd;
        logic walk_step;
        logic emit;
        logic next_leaf;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic live_one;
        logic scan_end;
        logic at_root;
        logic last_leaf;
    } status_t;

endpackage

// ----- rtl/huff_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huff_datapath
// Node stores, two-minimum scan, merge writes and leaf-to-root code walk.
// ----------------------------------------------------------------------------
module huff_datapath #(
    parameter int MAX_SYMBOLS = huff_pkg::DEF_MAX_SYMBOLS,
    parameter int WEIGHT_BITS = huff_pkg::DEF_WEIGHT_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  huff_pkg::in_item_t  item,
    input  huff_pkg::cmd_t      cmd,
    output huff_pkg::status_t   status,
    output huff_pkg::out_item_t result,
    output logic                result_valid
);
    import huff_pkg::*;

    localparam int NODE_CAP = 2 * MAX_SYMBOLS - 1;
    localparam int NW       = $clog2(NODE_CAP);
    localparam int NCW      = $clog2(NODE_CAP + 1);
    localparam int LW       = $clog2(MAX_SYMBOLS);
    localparam int LCW      = $clog2(MAX_SYMBOLS + 1);
    localparam int DW       = $clog2(MAX_SYMBOLS);
    localparam int WW       = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
    localparam logic [31:0] WMASK = (32'd1 << WEIGHT_BITS) - 32'd1;

    // memories
    logic [WW-1:0] wt_mem  [NODE_CAP];
    logic [NW-1:0] par_mem [NODE_CAP];
    logic          isr_mem [NODE_CAP];
    logic [7:0]    sym_mem [MAX_SYMBOLS];

    logic [NODE_CAP-1:0] alive_reg;
    logic [LCW-1:0] leaf_count_reg;
    logic [NCW-1:0] node_count_reg;
    logic [LCW-1:0] live_reg;
    logic           overflow_reg;

    logic [NW-1:0]  ptr_reg;
    logic           pend_vld_reg;
    logic [NW-1:0]  pend_idx_reg;
    logic           pend_alive_reg;
    logic [WW-1:0]  wt_rd_reg;

    logic           b1v_reg, b2v_reg;
    logic [NW-1:0]  b1_reg, b2_reg;
    logic [WW-1:0]  w1_reg, w2_reg;

    logic [LW-1:0]  emit_i_reg;
    logic [NW-1:0]  n_reg;
    logic [DW-1:0]  depth_reg;
    logic [30:0]    code_reg;
    logic [NW-1:0]  par_rd_reg;
    logic           isr_rd_reg;
    logic [7:0]     sym_rd_reg;

    out_item_t      result_reg;
    logic           result_valid_reg;

    logic           has_room;
    logic [LCW-1:0] lc_after;
    logic [LW-1:0]  load_idx;
    logic [WW-1:0]  w_in;
    logic [NW-1:0]  new_node;
    logic [NW-1:0]  root;
    logic [6:0]     depth_ext;
    logic           last_leaf;

    assign has_room  = leaf_count_reg < LCW'(MAX_SYMBOLS);
    assign lc_after  = has_room ? leaf_count_reg + LCW'(1) : leaf_count_reg;
    assign load_idx  = leaf_count_reg[LW-1:0];
    assign w_in      = WW'(32'(item.weight) & WMASK);
    assign new_node  = node_count_reg[NW-1:0];
    assign root      = NW'(node_count_reg - NCW'(1));
    assign depth_ext = 7'(depth_reg);
    assign last_leaf = (LCW'(emit_i_reg) + LCW'(1)) == leaf_count_reg;

    assign status.live_one  = live_reg == LCW'(1);
    assign status.scan_end  = (NCW'(ptr_reg) + NCW'(1)) == node_count_reg;
    assign status.at_root   = n_reg == root;
    assign status.last_leaf = last_leaf;

    // weight store: load or merge write, scan read
    always_ff @(posedge clk)
    begin
        if (cmd.load && has_room)
        begin
            wt_mem[NW'(load_idx)] <= w_in;
        end
        else if (cmd.merge_a)
        begin
            wt_mem[new_node] <= w1_reg + w2_reg;
        end
        if (cmd.scan_issue)
        begin
            wt_rd_reg <= wt_mem[ptr_reg];
        end
    end

    // parent / branch store
    always_ff @(posedge clk)
    begin
        if (cmd.merge_a)
        begin
            par_mem[b1_reg] <= new_node;
            isr_mem[b1_reg] <= 1'b0;
        end
        else if (cmd.merge_b)
        begin
            par_mem[b2_reg] <= new_node;
            isr_mem[b2_reg] <= 1'b1;
        end
        if (cmd.walk_rd)
        begin
            par_rd_reg <= par_mem[n_reg];
            isr_rd_reg <= isr_mem[n_reg];
        end
    end

    // leaf symbol store
    always_ff @(posedge clk)
    begin
        if (cmd.load && has_room)
        begin
            sym_mem[load_idx] <= item.symbol;
        end
        if (cmd.emit_init)
        begin
            sym_rd_reg <= sym_mem[emit_i_reg];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg        <= '0;
            leaf_count_reg   <= '0;
            node_count_reg   <= '0;
            live_reg         <= '0;
            overflow_reg     <= 1'b0;
            ptr_reg          <= '0;
            pend_vld_reg     <= 1'b0;
            b1v_reg          <= 1'b0;
            b2v_reg          <= 1'b0;
            emit_i_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            pend_vld_reg     <= cmd.scan_issue;
            result_valid_reg <= cmd.emit;

            if (cmd.load)
            begin
                if (has_room)
                begin
                    alive_reg[NW'(load_idx)] <= 1'b1;
                    leaf_count_reg <= lc_after;
                end
                else
                begin
                    overflow_reg <= 1'b1;
                end
                if (item.last_symbol)
                begin
                    node_count_reg <= NCW'(lc_after);
                    live_reg       <= lc_after;
                    emit_i_reg     <= '0;
                end
            end

            if (cmd.scan_init)
            begin
                ptr_reg <= '0;
                b1v_reg <= 1'b0;
                b2v_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_issue)
                begin
                    ptr_reg <= ptr_reg + NW'(1);
                end
                // ascending scan with strict compare keeps the lower index on ties
                if (pend_vld_reg && pend_alive_reg)
                begin
                    if (!b1v_reg || wt_rd_reg < w1_reg)
                    begin
                        b2v_reg <= b1v_reg;
                        b1v_reg <= 1'b1;
                    end
                    else if (!b2v_reg || wt_rd_reg < w2_reg)
                    begin
                        b2v_reg <= 1'b1;
                    end
                end
            end

            if (cmd.merge_a)
            begin
                alive_reg[b1_reg]   <= 1'b0;
                alive_reg[b2_reg]   <= 1'b0;
                alive_reg[new_node] <= 1'b1;
            end
            if (cmd.merge_b)
            begin
                node_count_reg <= node_count_reg + NCW'(1);
                live_reg       <= live_reg - LCW'(1);
            end

            if (cmd.next_leaf)
            begin
                if (last_leaf)
                begin
                    leaf_count_reg <= '0;
                    node_count_reg <= '0;
                    overflow_reg   <= 1'b0;
                end
                else
                begin
                    emit_i_reg <= emit_i_reg + LW'(1);
                end
            end
        end
    end

    // scan payload
    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= ptr_reg;
        pend_alive_reg <= alive_reg[ptr_reg];
        if (!cmd.scan_init && pend_vld_reg && pend_alive_reg)
        begin
            if (!b1v_reg || wt_rd_reg < w1_reg)
            begin
                b2_reg <= b1_reg;
                w2_reg <= w1_reg;
                b1_reg <= pend_idx_reg;
                w1_reg <= wt_rd_reg;
            end
            else if (!b2v_reg || wt_rd_reg < w2_reg)
            begin
                b2_reg <= pend_idx_reg;
                w2_reg <= wt_rd_reg;
            end
        end
    end

    // code walk
    always_ff @(posedge clk)
    begin
        if (cmd.emit_init)
        begin
            n_reg     <= NW'(emit_i_reg);
            depth_reg <= '0;
            code_reg  <= '0;
        end
        else if (cmd.walk_step)
        begin
            if (isr_rd_reg && depth_ext < 7'd31)
            begin
                code_reg[depth_ext[4:0]] <= 1'b1;
            end
            depth_reg <= depth_reg + DW'(1);
            n_reg     <= par_rd_reg;
        end
        if (cmd.emit)
        begin
            result_reg.out_symbol  <= sym_rd_reg;
            result_reg.code_bits   <= code_reg;
            result_reg.code_length <= (depth_ext > 7'd31) ? 5'd31 : depth_ext[4:0];
            result_reg.last_code   <= last_leaf;
            result_reg.too_many    <= overflow_reg;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result strobe held for two cycles");

    a_merge_has_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.merge_a |-> (b1v_reg && b2v_reg && b1_reg != b2_reg))
        else $error("merge without two distinct live nodes");

    a_scan_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_issue |-> (live_reg > LCW'(1)))
        else $error("scan started with fewer than two live nodes");

endmodule

// ----- rtl/huff_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huff_controller
// Sequencer for load, merge rounds and code emission.
// ----------------------------------------------------------------------------
module huff_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_symbol,
    input  huff_pkg::status_t status,
    output huff_pkg::cmd_t    cmd,
    output logic              busy
);
    import huff_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_CHECK     = 10'b0000000010,
        S_SCAN      = 10'b0000000100,
        S_DRAIN     = 10'b0000001000,
        S_MERGE_A   = 10'b0000010000,
        S_MERGE_B   = 10'b0000100000,
        S_EMIT_INIT = 10'b0001000000,
        S_WALK      = 10'b0010000000,
        S_WAIT      = 10'b0100000000,
        S_OUT       = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (last_symbol)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (status.live_one)
                begin
                    state_next = S_EMIT_INIT;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_MERGE_A;
            end
            S_MERGE_A:
            begin
                cmd.merge_a = 1'b1;
                state_next  = S_MERGE_B;
            end
            S_MERGE_B:
            begin
                cmd.merge_b = 1'b1;
                state_next  = S_CHECK;
            end
            S_EMIT_INIT:
            begin
                cmd.emit_init = 1'b1;
                state_next    = S_WALK;
            end
            S_WALK:
            begin
                if (status.at_root)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_WAIT;
                end
            end
            S_WAIT:
            begin
                cmd.walk_step = 1'b1;
                state_next    = S_WALK;
            end
            S_OUT:
            begin
                cmd.next_leaf = 1'b1;
                state_next    = status.last_leaf ? S_IDLE : S_EMIT_INIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/huffman_code_builder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_builder_unit
// Loads (symbol, weight) beats, builds a Huffman tree, emits one code per
// symbol in load order.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// item      in         start && !busy         in_item_t
// result    out        result_valid (1 cycle) out_item_t
//
// Loading takes a new beat whenever busy is low. After the last beat, each
// merge round scans the node store at one read per cycle. Each code is then
// built by a leaf-to-root parent walk, one parent read and one step per level.
// Reset is asynchronous, active low; stores are not cleared.
// The receiver cannot stall; busy holds off new items until the table is out.
// ----------------------------------------------------------------------------
module huffman_code_builder_unit #(
    parameter int MAX_SYMBOLS = huff_pkg::DEF_MAX_SYMBOLS,
    parameter int WEIGHT_BITS = huff_pkg::DEF_WEIGHT_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  huff_pkg::in_item_t  item,
    output logic                result_valid,
    output huff_pkg::out_item_t result
);
    import huff_pkg::*;

    cmd_t    cmd;
    status_t status;

    huff_controller u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .last_symbol (item.last_symbol),
        .status      (status),
        .cmd         (cmd),
        .busy        (busy)
    );

    huff_datapath #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

// ----- tb/tb_huffman_code_builder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_code_builder_unit
// Loads symbol tables of random size and weight into the code builder and
// checks every emitted code against a tree-building predictor. Directed tables,
// a full and an overfull table, then random tables under varying idle rates.
// ----------------------------------------------------------------------------
module tb_huffman_code_builder_unit;
    import huff_pkg::*;

    localparam int NSYM = DEF_MAX_SYMBOLS;
    localparam int NCAP = 2 * NSYM - 1;
    localparam int QUIET_LIMIT = 20000;

    typedef struct {
        logic [7:0]  symbol;
        logic [15:0] weight;
        logic        last;
        logic        known;
        out_item_t   code;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    item;
    logic        result_valid;
    out_item_t   result;

    // predictor state
    logic [20:0] tree_weight [NCAP];
    logic [5:0]  tree_parent [NCAP];
    logic        tree_right  [NCAP];
    logic        tree_live   [NCAP];
    logic [7:0]  sym_store   [NSYM];
    int          n_leaves;
    logic        dropped;

    out_item_t   code_queue[$];
    int          fails;
    int          quiet_cycles;
    int          send_idle_pct;

    huffman_code_builder_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_lightest(int n_nodes);
        int best;
        best = -1;
        for (int i = 0; i < n_nodes; i++)
            if (tree_live[i] && (best < 0 || tree_weight[i] < tree_weight[best]))
                best = i;
        if (best >= 0)
            tree_live[best] = 1'b0;
        return best;
    endfunction

    // Store one beat; on the last beat build the tree and queue the codes.
    task automatic predict_codes(in_item_t beat);
        int n_nodes;
        int live;
        int a;
        int b;
        int n;
        int depth;
        logic [63:0] bits;
        out_item_t code;
        if (n_leaves < NSYM)
        begin
            sym_store[n_leaves] = beat.symbol;
            tree_weight[n_leaves] = 21'(beat.weight);
            tree_live[n_leaves] = 1'b1;
            n_leaves++;
        end
        else
            dropped = 1'b1;
        if (!beat.last_symbol)
            return;
        n_nodes = n_leaves;
        live = n_leaves;
        while (live > 1 && n_nodes < NCAP)
        begin
            a = pick_lightest(n_nodes);
            b = pick_lightest(n_nodes);
            tree_weight[n_nodes] = tree_weight[a] + tree_weight[b];
            tree_live[n_nodes] = 1'b1;
            tree_parent[a] = 6'(n_nodes);
            tree_right[a] = 1'b0;
            tree_parent[b] = 6'(n_nodes);
            tree_right[b] = 1'b1;
            n_nodes++;
            live--;
        end
        for (int i = 0; i < n_leaves; i++)
        begin
            bits = '0;
            depth = 0;
            n = i;
            while (n != n_nodes - 1)
            begin
                if (tree_right[n])
                    bits[depth] = 1'b1;
                depth++;
                n = tree_parent[n];
            end
            code.out_symbol = sym_store[i];
            code.code_bits = bits[30:0];
            code.code_length = depth > 31 ? 5'd31 : 5'(depth);
            code.last_code = (i == n_leaves - 1);
            code.too_many = dropped;
            code_queue.push_back(code);
        end
        n_leaves = 0;
        dropped = 1'b0;
    endtask

    task automatic send_beat(logic [7:0] sym, logic [15:0] w, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item <= '{symbol: sym, weight: w, last_symbol: last};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_codes('{symbol: sym, weight: w, last_symbol: last});
    endtask

    // Sends one table of n random beats; callers send mostly small tables and a few near or over capacity.
    task automatic send_table(int n, int wmax);
        for (int i = 0; i < n; i++)
            send_beat(8'($urandom), 16'($urandom_range(wmax)), i == n - 1);
    endtask

    task automatic drain_codes();
        start <= 1'b0;
        while (code_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (code_queue.size() == 0)
            begin
                $display("%0t: unexpected code %p", $time, result);
                fails++;
            end
            else if (result !== code_queue[0])
            begin
                $display("%0t: code mismatch exp %p got %p", $time, code_queue[0], result);
                fails++;
                void'(code_queue.pop_front());
            end
            else
                void'(code_queue.pop_front());
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** huffman_code_builder_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin
        dir_row_t dir_rows[$];
        int sizes;
        fails = 0;
        quiet_cycles = 0;
        n_leaves = 0;
        dropped = 1'b0;
        send_idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single symbol: zero-length code
        dir_rows.push_back('{8'hFF, 16'hFFFF, 1'b1, 1'b1, '{8'hFF, 31'd0, 5'd0, 1'b1, 1'b0}});
        dir_rows.push_back('{8'h00, 16'h0000, 1'b1, 1'b1, '{8'h00, 31'd0, 5'd0, 1'b1, 1'b0}});
        // two symbols, equal weight: first loaded gets 0
        dir_rows.push_back('{8'h00, 16'h0000, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'hFF, 16'h0000, 1'b1, 1'b0, '0});
        // extremes of weight with ties
        dir_rows.push_back('{8'hAA, 16'hFFFF, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h55, 16'h0001, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'h0F, 16'h0001, 1'b0, 1'b0, '0});
        dir_rows.push_back('{8'hF0, 16'hFFFF, 1'b1, 1'b0, '0});
        foreach (dir_rows[r])
        begin
            send_beat(dir_rows[r].symbol, dir_rows[r].weight, dir_rows[r].last);
            if (dir_rows[r].known)
            begin
                // typed value cross-checks the predictor
                if (code_queue[code_queue.size() - 1] !== dir_rows[r].code)
                begin
                    $display("%0t: directed row %0d exp %p got %p", $time, r,
                             dir_rows[r].code, code_queue[code_queue.size() - 1]);
                    fails++;
                end
            end
        end
        drain_codes();
        // fibonacci weights, clipped to 16 bits: a deep tree at full capacity
        begin
            int fa;
            int fb;
            int ft;
            fa = 1;
            fb = 1;
            for (int i = 0; i < NSYM; i++)
            begin
                send_beat(8'(i), 16'(fa > 65535 ? 65535 : fa), i == NSYM - 1);
                ft = fa + fb;
                fa = fb;
                fb = ft;
            end
        end
        // overflow, marked last on a dropped beat
        send_table(NSYM + 2, 65535);
        drain_codes();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 48 : 0;
            sizes = 0;
            while (sizes < 48)
            begin
                int n;
                n = ($urandom_range(9) == 0) ? $urandom_range(NSYM + 3, NSYM - 2)
                                             : $urandom_range(6, 1);
                send_table(n, $urandom_range(1) ? 65535 : 7);
                sizes += n;
                if ($urandom_range(7) == 0)
                    drain_codes();
            end
            drain_codes();
        end

        if (fails == 0)
            $display("** huffman_code_builder_unit: PASSED **");
        else
            $display("** huffman_code_builder_unit: FAILED **");
        $finish;
    end
endmodule
